>>> rtl/core/smd_pkg.sv
// Shared types and constants for the stereo meter and decimator.
`default_nettype none
package smd_pkg;

  // Default right shift applied to a sample before it is squared.
  localparam int unsigned SMD_METER_SHIFT = 7;

  // Result kinds on the output channel.
  typedef enum logic {
    KIND_MONO  = 1'b0,
    KIND_METER = 1'b1
  } smd_kind_t;

  // Input modes.
  localparam logic MODE_FRAME = 1'b0;
  localparam logic MODE_DRAIN = 1'b1;

  // Control handed from the top level to the lanes and the merge stage.
  typedef struct packed {
    logic load;   // Stage one takes a new word.
    logic step;   // Stage one word moves into the state update.
    logic drain;  // The moving word is a drain request.
  } smd_ctl_t;

endpackage
`default_nettype wire

>>> rtl/core/smd_meter_lane.sv
// One channel meter lane: shifted square and magnitude, then sum and peak.
`default_nettype none
module smd_meter_lane import smd_pkg::*; #(
  parameter int unsigned METER_SHIFT = SMD_METER_SHIFT
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire smd_ctl_t           ctl,
  input  wire logic signed [15:0] sample,
  output logic             [31:0] sum_sq,
  output logic             [15:0] peak
);

  logic signed [15:0] shifted;
  logic        [16:0] neg_shifted;
  logic        [15:0] shifted_mag;
  logic        [16:0] neg_sample;
  logic        [15:0] sample_mag;
  logic        [31:0] sq_r;
  logic        [15:0] mag_r;
  logic        [31:0] acc_r;
  logic        [31:0] acc_nxt;
  logic        [15:0] peak_r;
  logic        [15:0] peak_nxt;

  // Stage one: the magnitude of -32768 is 32768, which still fits 16 bits.
  always_comb begin
    shifted     = sample >>> METER_SHIFT;
    neg_shifted = 17'd0 - {shifted[15], shifted};
    shifted_mag = shifted[15] ? neg_shifted[15:0] : shifted;
    neg_sample  = 17'd0 - {sample[15], sample};
    sample_mag  = sample[15] ? neg_sample[15:0] : sample;
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      sq_r  <= shifted_mag * shifted_mag;
      mag_r <= sample_mag;
    end
  end

  // Stage two: accumulate, or clear on a drain.
  always_comb begin
    acc_nxt  = acc_r;
    peak_nxt = peak_r;
    if (ctl.step) begin
      if (ctl.drain) begin
        acc_nxt  = 32'd0;
        peak_nxt = 16'd0;
      end else begin
        acc_nxt  = acc_r + sq_r;
        peak_nxt = (mag_r > peak_r) ? mag_r : peak_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= 32'd0;
      peak_r <= 16'd0;
    end else begin
      acc_r  <= acc_nxt;
      peak_r <= peak_nxt;
    end
  end

  assign sum_sq = acc_r;
  assign peak   = peak_r;

endmodule
`default_nettype wire

>>> rtl/core/smd_merge.sv
// Merge stage: frame count, 2:1 mono decimator and the output register.
`default_nettype none
module smd_merge import smd_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire smd_ctl_t           ctl,
  input  wire logic signed [15:0] mono,
  input  wire logic        [31:0] lane_sum_l,
  input  wire logic        [31:0] lane_sum_r,
  input  wire logic        [15:0] lane_peak_l,
  input  wire logic        [15:0] lane_peak_r,
  input  wire logic               out_stall,
  output logic                    out_valid,
  output logic                    out_kind,
  output logic signed      [15:0] out_mono_sample,
  output logic             [31:0] out_sample_index,
  output logic             [31:0] out_sum_sq_left,
  output logic             [31:0] out_sum_sq_right,
  output logic             [31:0] out_frames_seen,
  output logic             [15:0] out_peak_left,
  output logic             [15:0] out_peak_right
);

  logic signed [15:0] held_r, held_nxt;
  logic               pair_r, pair_nxt;
  logic        [31:0] dec_cnt_r, dec_cnt_nxt;
  logic        [31:0] frames_r, frames_nxt;
  logic               valid_r, valid_nxt;
  logic               emit;
  logic signed [16:0] pair_sum;
  logic signed [16:0] pair_avg;

  logic               kind_r;
  logic signed [15:0] mono_r;
  logic        [31:0] index_r, sum_l_r, sum_r_r, frames_out_r;
  logic        [15:0] peak_l_r, peak_r_r;

  assign pair_sum = {held_r[15], held_r} + {mono[15], mono};
  assign pair_avg = pair_sum >>> 1;
  assign emit     = ctl.step && (ctl.drain || pair_r);

  always_comb begin
    held_nxt    = held_r;
    pair_nxt    = pair_r;
    dec_cnt_nxt = dec_cnt_r;
    frames_nxt  = frames_r;
    valid_nxt   = valid_r;
    if (!out_stall) begin
      valid_nxt = 1'b0;
    end
    if (emit) begin
      valid_nxt = 1'b1;
    end
    if (ctl.step) begin
      if (ctl.drain) begin
        frames_nxt = 32'd0;
      end else begin
        frames_nxt = frames_r + 32'd1;
        if (pair_r) begin
          pair_nxt    = 1'b0;
          dec_cnt_nxt = dec_cnt_r + 32'd1;
        end else begin
          held_nxt = mono;
          pair_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r    <= 16'sd0;
      pair_r    <= 1'b0;
      dec_cnt_r <= 32'd0;
      frames_r  <= 32'd0;
      valid_r   <= 1'b0;
    end else begin
      held_r    <= held_nxt;
      pair_r    <= pair_nxt;
      dec_cnt_r <= dec_cnt_nxt;
      frames_r  <= frames_nxt;
      valid_r   <= valid_nxt;
    end
  end

  // Output payload; fields that the kind does not use read as zero.
  always_ff @(posedge clk) begin
    if (emit) begin
      if (ctl.drain) begin
        kind_r       <= KIND_METER;
        mono_r       <= 16'sd0;
        index_r      <= 32'd0;
        sum_l_r      <= lane_sum_l;
        sum_r_r      <= lane_sum_r;
        frames_out_r <= frames_r;
        peak_l_r     <= lane_peak_l;
        peak_r_r     <= lane_peak_r;
      end else begin
        kind_r       <= KIND_MONO;
        mono_r       <= pair_avg[15:0];
        index_r      <= dec_cnt_r;
        sum_l_r      <= 32'd0;
        sum_r_r      <= 32'd0;
        frames_out_r <= 32'd0;
        peak_l_r     <= 16'd0;
        peak_r_r     <= 16'd0;
      end
    end
  end

  assign out_valid        = valid_r;
  assign out_kind         = kind_r;
  assign out_mono_sample  = mono_r;
  assign out_sample_index = index_r;
  assign out_sum_sq_left  = sum_l_r;
  assign out_sum_sq_right = sum_r_r;
  assign out_frames_seen  = frames_out_r;
  assign out_peak_left    = peak_l_r;
  assign out_peak_right   = peak_r_r;

endmodule
`default_nettype wire

>>> rtl/core/stereo_meter_decimator.sv
// Top level of the stereo level meter with 2:1 mono decimator.
//
//   Channel  Direction  Handshake           Payload
//   in_      input      in_valid/in_stall   mode, left, right
//   out_     output     out_valid/out_stall kind, mono_sample, sample_index,
//                                           sum_sq_left, sum_sq_right,
//                                           frames_seen, peak_left, peak_right
//
// One word is accepted every cycle while the output side keeps up. A word
// passes two stages: stage one squares and takes the magnitude in each lane
// at the accepting edge, and stage two updates the sums, peaks and the
// decimator and loads the result register once stage one advances. Reset is
// synchronous and active low and clears all meters, the held mono value and
// the decimated count. A stall on the output holds the result and backs up
// into in_stall only once stage one is also full, so up to two words stay in
// flight during a stall.
`default_nettype none
module stereo_meter_decimator import smd_pkg::*; #(
  parameter int unsigned METER_SHIFT = SMD_METER_SHIFT
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               in_mode,
  input  wire logic signed [15:0] in_left,
  input  wire logic signed [15:0] in_right,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    out_kind,
  output logic signed      [15:0] out_mono_sample,
  output logic             [31:0] out_sample_index,
  output logic             [31:0] out_sum_sq_left,
  output logic             [31:0] out_sum_sq_right,
  output logic             [31:0] out_frames_seen,
  output logic             [15:0] out_peak_left,
  output logic             [15:0] out_peak_right
);

  logic               s1_valid_r, s1_valid_nxt;
  logic               s1_mode_r;
  logic signed [15:0] s1_mono_r;
  logic signed [16:0] mix_sum;
  logic signed [16:0] mix_half;
  logic               advance;
  logic               accept;
  smd_ctl_t           ctl;
  logic        [31:0] sum_l, sum_r;
  logic        [15:0] peak_l, peak_r;

  // Stage one moves on whenever the output register is free or being read.
  assign advance  = s1_valid_r && (!out_valid || !out_stall);
  assign in_stall = s1_valid_r && !advance;
  assign accept   = in_valid && !in_stall;

  assign ctl.load  = accept;
  assign ctl.step  = advance;
  assign ctl.drain = (s1_mode_r == MODE_DRAIN);

  // The downmix is the arithmetic half of the 17-bit sum.
  assign mix_sum  = {in_left[15], in_left} + {in_right[15], in_right};
  assign mix_half = mix_sum >>> 1;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_mode_r <= in_mode;
      s1_mono_r <= mix_half[15:0];
    end
  end

  // Two meter lanes work side by side, one per channel.
  smd_meter_lane #(.METER_SHIFT(METER_SHIFT)) u_lane_left (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ctl),
    .sample (in_left),
    .sum_sq (sum_l),
    .peak   (peak_l)
  );

  smd_meter_lane #(.METER_SHIFT(METER_SHIFT)) u_lane_right (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ctl),
    .sample (in_right),
    .sum_sq (sum_r),
    .peak   (peak_r)
  );

  // The merge stage combines the lane readouts with the decimator.
  smd_merge u_merge (
    .clk              (clk),
    .rst_n            (rst_n),
    .ctl              (ctl),
    .mono             (s1_mono_r),
    .lane_sum_l       (sum_l),
    .lane_sum_r       (sum_r),
    .lane_peak_l      (peak_l),
    .lane_peak_r      (peak_r),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .out_kind         (out_kind),
    .out_mono_sample  (out_mono_sample),
    .out_sample_index (out_sample_index),
    .out_sum_sq_left  (out_sum_sq_left),
    .out_sum_sq_right (out_sum_sq_right),
    .out_frames_seen  (out_frames_seen),
    .out_peak_left    (out_peak_left),
    .out_peak_right   (out_peak_right)
  );

endmodule
`default_nettype wire

>>> rtl/core/smd_checker.sv
// Port-level checker for the stereo meter decimator, with its bind.
`default_nettype none
module smd_checker import smd_pkg::*; (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic        out_kind,
  input wire logic [15:0] out_mono_sample,
  input wire logic [31:0] out_sample_index,
  input wire logic [31:0] out_sum_sq_left,
  input wire logic [31:0] out_sum_sq_right,
  input wire logic [31:0] out_frames_seen,
  input wire logic [15:0] out_peak_left,
  input wire logic [15:0] out_peak_right
);

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_kind)
      && $stable(out_mono_sample) && $stable(out_sample_index))
    else $error("output word changed under stall");

  // A decimated sample carries no meter readings.
  a_mono_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_MONO |-> out_sum_sq_left == 32'd0
      && out_sum_sq_right == 32'd0 && out_frames_seen == 32'd0
      && out_peak_left == 16'd0 && out_peak_right == 16'd0)
    else $error("meter fields set on a mono word");

  // A meter readout carries no sample and peaks never pass full scale.
  a_meter_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_METER |-> out_mono_sample == 16'd0
      && out_sample_index == 32'd0 && out_peak_left <= 16'h8000
      && out_peak_right <= 16'h8000)
    else $error("bad meter readout word");

  // No result is shown in the cycle after reset.
  a_reset_quiet: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("output valid right after reset");

endmodule

bind stereo_meter_decimator smd_checker u_smd_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_kind         (out_kind),
  .out_mono_sample  (out_mono_sample),
  .out_sample_index (out_sample_index),
  .out_sum_sq_left  (out_sum_sq_left),
  .out_sum_sq_right (out_sum_sq_right),
  .out_frames_seen  (out_frames_seen),
  .out_peak_left    (out_peak_left),
  .out_peak_right   (out_peak_right)
);
`default_nettype wire
